// File: hw/rtl/blbi_pkg.sv
`default_nettype none

package blbi_pkg;

  // field widths
  localparam int unsigned MvWidth    = 16;
  localparam int unsigned LevelWidth = 4;
  localparam int unsigned DurWidth   = 16;
  localparam int unsigned NumLevels  = 10;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataWidth  = 24;
  localparam int unsigned OutDataWidth = 8;

  // command codes carried in the input tuser
  typedef enum logic {
    CmdTick   = 1'b0,
    CmdUpdate = 1'b1
  } cmd_e;

  // level codes
  localparam logic [LevelWidth-1:0] LevelEmpty = 4'd0;
  localparam logic [LevelWidth-1:0] LevelDone  = 4'd9;

  // one result beat
  typedef struct packed {
    logic [LevelWidth-1:0] level;
    logic                  led_on;
  } result_t;

  // sort a reading into a level, strict greater-than compares
  function automatic logic [LevelWidth-1:0] classify(
    input logic [MvWidth-1:0] mv,
    input logic               done
  );
    logic [LevelWidth-1:0] lvl;
    if (done) begin
      lvl = LevelDone;
    end else if (mv > 16'd4200) begin
      lvl = 4'd8;
    end else if (mv > 16'd4100) begin
      lvl = 4'd7;
    end else if (mv > 16'd4000) begin
      lvl = 4'd6;
    end else if (mv > 16'd3900) begin
      lvl = 4'd5;
    end else if (mv > 16'd3800) begin
      lvl = 4'd4;
    end else if (mv > 16'd3700) begin
      lvl = 4'd3;
    end else if (mv > 16'd3600) begin
      lvl = 4'd2;
    end else if (mv > 16'd3300) begin
      lvl = 4'd1;
    end else begin
      lvl = LevelEmpty;
    end
    return lvl;
  endfunction

  // dark phase duration in ms per level
  function automatic logic [DurWidth-1:0] pause_ms(input logic [LevelWidth-1:0] lvl);
    logic [DurWidth-1:0] d;
    case (lvl)
      4'd0:    d = 16'd20000;
      4'd1:    d = 16'd10000;
      4'd2:    d = 16'd5000;
      4'd3:    d = 16'd2000;
      4'd4:    d = 16'd1000;
      4'd5:    d = 16'd1000;
      4'd6:    d = 16'd1000;
      4'd7:    d = 16'd1000;
      4'd8:    d = 16'd100;
      4'd9:    d = 16'd180;
      default: d = 16'd20000;
    endcase
    return d;
  endfunction

  // lit phase duration in ms per level
  function automatic logic [DurWidth-1:0] light_ms(input logic [LevelWidth-1:0] lvl);
    logic [DurWidth-1:0] d;
    case (lvl)
      4'd5:    d = 16'd500;
      4'd6:    d = 16'd1000;
      4'd7:    d = 16'd2000;
      4'd8:    d = 16'd1000;
      default: d = 16'd20;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/battery_level_blink_indicator_core.sv
// output: an accepted item's result beat is registered in the output buffer
// throughput: one item per cycle while the skid entry is free; the state update and level compare chain
// finish in the cycle of acceptance, and a two-entry output buffer keeps
// input ready high while one result waits downstream
// reset: LED dark, level 0, first pause of 20000 ticks loaded, buffers empty
`default_nettype none

module battery_level_blink_indicator_core #(
  parameter int unsigned COUNT_BITS = 15
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input beats
  input  wire logic                                 s_axis_tvalid_i,
  output      logic                                 s_axis_tready_o,
  // [15:0] voltage_mv, [16] charge_finished, [23:17] zero
  input  wire logic [blbi_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  // [0] cmd
  input  wire logic                                 s_axis_tuser_i,
  // result beats
  output      logic                                 m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // [0] led_on, [4:1] level, [7:5] zero
  output      logic [blbi_pkg::OutDataWidth-1:0]    m_axis_tdata_o
);

  // blink state
  logic [COUNT_BITS-1:0]               remaining_q, remaining_d;
  logic                                lit_q, lit_d;
  logic [blbi_pkg::LevelWidth-1:0]     level_q, level_d;

  // output buffer
  logic                                out_valid_q, skid_valid_q;
  blbi_pkg::result_t                   out_data_q, skid_data_q, result;

  logic                                accept, pop;
  logic [blbi_pkg::LevelWidth-1:0]     lvl_sel;
  logic                                phase_end;
  logic [blbi_pkg::MvWidth-1:0]        mv;
  logic                                done;
  blbi_pkg::cmd_e                      cmd;

  assign s_axis_tready_o = ~skid_valid_q;
  assign accept          = s_axis_tvalid_i & ~skid_valid_q;
  assign pop             = out_valid_q & m_axis_tready_i;

  // unpack the input beat
  assign mv   = s_axis_tdata_i[blbi_pkg::MvWidth-1:0];
  assign done = s_axis_tdata_i[blbi_pkg::MvWidth];
  assign cmd  = blbi_pkg::cmd_e'(s_axis_tuser_i);

  // durations come from the level in force before this item
  assign lvl_sel   = (level_q < 4'(blbi_pkg::NumLevels)) ? level_q : blbi_pkg::LevelEmpty;
  assign phase_end = (remaining_q[COUNT_BITS-1:1] == '0);

  // next blink state
  always_comb begin
    remaining_d = remaining_q;
    lit_d       = lit_q;
    level_d     = level_q;
    case (cmd)
      blbi_pkg::CmdUpdate: begin
        level_d = blbi_pkg::classify(mv, done);
      end
      blbi_pkg::CmdTick: begin
        if (phase_end) begin
          lit_d = ~lit_q;
          if (lit_q) begin
            remaining_d = COUNT_BITS'(blbi_pkg::pause_ms(lvl_sel));
          end else begin
            remaining_d = COUNT_BITS'(blbi_pkg::light_ms(lvl_sel));
          end
        end else begin
          remaining_d = remaining_q - COUNT_BITS'(1);
        end
      end
      default: begin
        remaining_d = remaining_q;
      end
    endcase
  end

  assign result.led_on = lit_d;
  assign result.level  = level_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= COUNT_BITS'(blbi_pkg::pause_ms(blbi_pkg::LevelEmpty));
      lit_q       <= 1'b0;
      level_q     <= blbi_pkg::LevelEmpty;
    end else if (accept) begin
      remaining_q <= remaining_d;
      lit_q       <= lit_d;
      level_q     <= level_d;
    end
  end

  // output buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_data_q <= skid_valid_q ? skid_data_q : result;
    end else if (accept) begin
      skid_data_q <= result;
    end
  end

  // pack the result beat
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_data_q};

endmodule

`default_nettype wire
